// ----- hw/rtl/gbr_pkg.sv -----
package gbr_pkg;

    localparam int COLS   = 64;
    localparam int CW     = 6;
    localparam int NW     = 7;
    localparam int CHUNK  = 8;
    localparam int NCHUNK = COLS / CHUNK;
    localparam int KW     = 3;

    typedef logic [COLS-1:0] t_row;
    typedef logic [NW-1:0]   t_cnt;

    typedef struct packed {
        logic load;
        logic drop;
        logic step;
        logic rd;
        logic xr;
        logic ins;
        logic cnt;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic v_zero;
        logic v_bit;
        logic piv_valid;
        logic col_last;
        logic cnt_last;
        logic store_full;
    } t_status;

endpackage

// ----- hw/rtl/gbr_datapath.sv -----
module gbr_datapath #(
    parameter int MAX_ROWS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbr_pkg::t_cmd   i_cmd,
    output gbr_pkg::t_status o_status,
    input  gbr_pkg::t_row   i_row_mask,
    input  logic            i_cfg_valid,
    input  gbr_pkg::t_cnt   i_cfg_data,
    output gbr_pkg::t_cnt   o_rank,
    output logic            o_overflow
);
    import gbr_pkg::*;

    localparam int RW = $clog2(MAX_ROWS + 1);

    t_row            r_v;
    t_row            r_rdata;
    t_row            r_basis [COLS];
    logic [COLS-1:0] r_valid;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_rows;
    logic            r_ovf;
    t_cnt            r_cols;
    logic [KW-1:0]   r_k;
    t_cnt            r_acc;
    logic [3:0]      chunk_cnt;

    // Pivots with a column below the configured count, taken eight columns a cycle.
    always_comb begin
        logic [CW-1:0] idx;
        chunk_cnt = '0;
        idx = '0;
        for (int j = 0; j < CHUNK; j++) begin
            idx = {r_k, 3'(j)};
            if (r_valid[idx] && ({1'b0, idx} < r_cols)) begin
                chunk_cnt = chunk_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_col   <= '0;
            r_rows  <= '0;
            r_ovf   <= 1'b0;
            r_cols  <= t_cnt'(COLS);
            r_k     <= '0;
            r_acc   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cols <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_col  <= '0;
                r_rows <= r_rows + RW'(1);
            end
            if (i_cmd.drop) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.step || i_cmd.xr) begin
                r_col <= r_col + CW'(1);
            end
            if (i_cmd.ins) begin
                r_valid[r_col] <= 1'b1;
            end
            if (i_cmd.cnt) begin
                r_acc <= r_acc + NW'(chunk_cnt);
                r_k   <= r_k + KW'(1);
            end
            if (i_cmd.emit) begin
                r_valid <= '0;
                r_rows  <= '0;
                r_ovf   <= 1'b0;
                r_acc   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= i_row_mask;
        end else if (i_cmd.xr) begin
            r_v <= r_v ^ r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            r_basis[r_col] <= r_v;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_basis[r_col];
        end
    end

    assign o_status.v_zero     = (r_v == '0);
    assign o_status.v_bit      = r_v[r_col];
    assign o_status.piv_valid  = r_valid[r_col];
    assign o_status.col_last   = (r_col == CW'(COLS - 1));
    assign o_status.cnt_last   = (r_k == KW'(NCHUNK - 1));
    assign o_status.store_full = (r_rows == RW'(MAX_ROWS));

    assign o_rank     = r_acc;
    assign o_overflow = r_ovf;

endmodule

// ----- hw/rtl/gbr_ctrl.sv -----
module gbr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last_row,
    input  gbr_pkg::t_status i_status,
    output gbr_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import gbr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_XOR   = 3'd3;
    localparam logic [2:0] S_COUNT = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_last;
    logic       n_last;
    logic [2:0] row_end;

    assign row_end = r_last ? S_COUNT : S_IDLE;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_last = i_last_row;
                    if (i_status.store_full) begin
                        o_cmd.drop = 1'b1;
                        n_state    = i_last_row ? S_COUNT : S_IDLE;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.v_zero) begin
                    n_state = row_end;
                end else if (i_status.v_bit) begin
                    if (i_status.piv_valid) begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_WAIT;
                    end else begin
                        o_cmd.ins = 1'b1;
                        n_state   = row_end;
                    end
                end else if (i_status.col_last) begin
                    n_state = row_end;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_WAIT: begin
                n_state = S_XOR;
            end
            S_XOR: begin
                o_cmd.xr = 1'b1;
                n_state  = S_SCAN;
            end
            S_COUNT: begin
                o_cmd.cnt = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_EMIT);

endmodule

// ----- hw/rtl/gf2_bitmask_rank_unit.sv -----
// Rows of a GF(2) matrix are taken one beat at a time while busy is low, and
// each row is reduced at once against a basis kept by pivot column, scanning
// one column a cycle except at a column that needs an XOR with a stored basis
// row, where it reads that row from the basis memory and passes through the
// wait and XOR states before it goes on. A row dropped past MAX_ROWS is not
// scanned. After the last row, the pivots below the configured column count
// are counted eight columns a cycle, and the rank and overflow flag appear
// for exactly one cycle with o_done high. The receiver cannot stall that
// beat, so it must take it then.
module gf2_bitmask_rank_unit #(
    parameter int MAX_ROWS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  gbr_pkg::t_row i_row_mask,
    input  logic          i_last_row,
    output logic          o_done,
    output gbr_pkg::t_cnt o_rank,
    output logic          o_overflow,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  gbr_pkg::t_cnt i_cfg_data
);
    import gbr_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    gbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_row (i_last_row),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (o_done)
    );

    gbr_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_row_mask  (i_row_mask),
        .i_cfg_valid (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_rank      (o_rank),
        .o_overflow  (o_overflow)
    );

endmodule

// ----- hw/rtl/gbr_checker.sv -----
module gbr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input gbr_pkg::t_cnt o_rank
);
    import gbr_pkg::*;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result beat outside a busy period");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result beat lasted more than one cycle");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("busy held after the result beat");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done) else $error("result right after an accepted row");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rank <= t_cnt'(COLS))) else $error("rank beyond column count");

endmodule

bind gf2_bitmask_rank_unit gbr_checker u_gbr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rank  (o_rank)
);

// ----- tb/sv/gf2_bitmask_rank_checker.sv -----
module gf2_bitmask_rank_checker #(
    parameter int ROW_CAP = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  gbr_pkg::t_row i_row_mask,
    input  logic          i_last_row,
    input  logic          o_done,
    input  gbr_pkg::t_cnt o_rank,
    input  logic          o_overflow,
    input  logic          i_cfg_valid,
    input  logic          o_cfg_ready,
    input  gbr_pkg::t_cnt i_cfg_data,
    output int            pending,
    output int            fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import gbr_pkg::*;

    typedef struct packed {
        t_cnt rank;
        logic ovf;
    } t_rank_result;

    t_row         rows_held [ROW_CAP];
    int           rows_held_cnt;
    logic         ovf_seen;
    t_cnt         cols_cfg;
    t_rank_result rank_expected [$];
    int           errs;

    function automatic t_cnt gf2_rank(input int n, input t_cnt cols);
        t_row m [ROW_CAP];
        t_row t;
        int   nc;
        int   rk;
        int   p;
        m  = rows_held;
        nc = (cols > COLS) ? COLS : int'(cols);
        rk = 0;
        for (int c = 0; c < nc; c++) begin
            p = rk;
            while (p < n && !m[p][c]) p++;
            if (p < n) begin
                t     = m[rk];
                m[rk] = m[p];
                m[p]  = t;
                for (int r = 0; r < n; r++) begin
                    if (r != rk && m[r][c]) m[r] ^= m[rk];
                end
                rk++;
            end
        end
        return t_cnt'(rk);
    endfunction

    always @(posedge i_clk) begin
        t_rank_result want;
        if (!i_rst_n) begin
            rows_held_cnt = 0;
            ovf_seen      = 1'b0;
            cols_cfg      = t_cnt'(COLS);
            errs          = 0;
            rank_expected.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) cols_cfg = i_cfg_data;
            if (start && !busy) begin
                if (rows_held_cnt < ROW_CAP) begin
                    rows_held[rows_held_cnt] = i_row_mask;
                    rows_held_cnt++;
                end else begin
                    ovf_seen = 1'b1;
                end
                if (i_last_row) begin
                    want.rank = gf2_rank(rows_held_cnt, cols_cfg);
                    want.ovf  = ovf_seen;
                    rank_expected.push_back(want);
                    rows_held_cnt = 0;
                    ovf_seen      = 1'b0;
                end
            end
            if (o_done) begin
                if (rank_expected.size() == 0) begin
                    $error("unexpected result beat: rank %0d overflow %0d", o_rank, o_overflow);
                    errs++;
                end else begin
                    want = rank_expected.pop_front();
                    if (o_rank !== want.rank) begin
                        $error("rank mismatch: expected %0d, actual %0d", want.rank, o_rank);
                        errs++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $error("overflow mismatch: expected %0d, actual %0d",
                               want.ovf, o_overflow);
                        errs++;
                    end
                end
            end
        end
        pending    <= rank_expected.size();
        fail_count <= errs;
    end

endmodule

// ----- tb/sv/gf2_bitmask_rank_unit_tb.sv -----
module gf2_bitmask_rank_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gbr_pkg::*;

    localparam int ROW_CAP    = 64;
    localparam int ROW_TARGET = 2000;
    localparam int CALM_AFTER = 1800;
    localparam int STALL_MAX  = 4000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_row i_row_mask;
    logic i_last_row;
    logic o_done;
    t_cnt o_rank;
    logic o_overflow;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_cnt i_cfg_data;
    int   pending;
    int   fail_count;
    int   stall_cycles;
    int   rows_sent;

    gf2_bitmask_rank_unit #(.MAX_ROWS(ROW_CAP)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_row_mask  (i_row_mask),
        .i_last_row  (i_last_row),
        .o_done      (o_done),
        .o_rank      (o_rank),
        .o_overflow  (o_overflow),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    gf2_bitmask_rank_checker #(.ROW_CAP(ROW_CAP)) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_row_mask  (i_row_mask),
        .i_last_row  (i_last_row),
        .o_done      (o_done),
        .o_rank      (o_rank),
        .o_overflow  (o_overflow),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Any accepted beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_row rand_row();
        return {$urandom, $urandom};
    endfunction

    task automatic send_row(input t_row mask, input logic last, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_row_mask <= mask;
        i_last_row <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rows_sent++;
    endtask

    task automatic program_cols(input t_cnt value);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_matrix(input bit may_idle);
        int   nrows;
        int   style;
        t_row r;
        t_row made [$];
        nrows = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 10);
        style = $urandom_range(0, 3);
        for (int i = 0; i < nrows; i++) begin
            r = rand_row();
            case (($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : style)
                0: ;
                1: begin
                    case ($urandom_range(0, 5))
                        0:       r = '0;
                        1:       r = '1;
                        default: r = t_row'(1) << $urandom_range(0, COLS - 1);
                    endcase
                end
                2: begin
                    if (made.size() > 0) begin
                        r = made[$urandom_range(0, made.size() - 1)]
                          ^ made[$urandom_range(0, made.size() - 1)];
                    end
                end
                default: begin
                    r = (r >> (i % COLS)) << (i % COLS);
                    r[i % COLS] = 1'b1;
                end
            endcase
            made.push_back(r);
            send_row(r, i == nrows - 1, may_idle);
        end
    endtask

    initial begin
        t_cnt cfg_pick;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_row_mask  <= '0;
        i_last_row  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        rows_sent   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_row('0, 1'b1, 1'b0);
        send_row('1, 1'b1, 1'b1);
        send_row(t_row'(1), 1'b0, 1'b1);
        send_row(t_row'(1), 1'b1, 1'b0);
        send_row(t_row'(1) << (COLS - 1), 1'b1, 1'b0);
        program_cols(t_cnt'(1));
        send_row(t_row'(1) << (COLS - 1), 1'b1, 1'b0);
        send_row((t_row'(1) << (COLS - 1)) | t_row'(1), 1'b1, 1'b0);
        program_cols(t_cnt'(0));
        send_row('1, 1'b1, 1'b0);
        program_cols(t_cnt'(127));
        send_row(64'h0F0F_0000_1234_0001, 1'b0, 1'b0);
        send_row(64'h8000_00FF_0000_0003, 1'b0, 1'b1);
        send_row(64'h8F0F_00FF_1234_0002, 1'b1, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
        program_cols(t_cnt'(63));
        send_row(t_row'(1) << (COLS - 1), 1'b0, 1'b0);
        send_row(t_row'(1) << (COLS - 2), 1'b1, 1'b0);
        program_cols(t_cnt'(COLS));

        rows_sent = 0;
        while (rows_sent < ROW_TARGET) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 7))
                    0:       cfg_pick = t_cnt'(0);
                    1:       cfg_pick = t_cnt'(1);
                    2:       cfg_pick = t_cnt'(127);
                    3:       cfg_pick = t_cnt'($urandom_range(0, 127));
                    4, 5:    cfg_pick = t_cnt'($urandom_range(1, COLS));
                    default: cfg_pick = t_cnt'(COLS);
                endcase
                program_cols(cfg_pick);
            end
            send_matrix(rows_sent < CALM_AFTER);
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/gbr_pkg.sv
hw/rtl/gbr_datapath.sv
hw/rtl/gbr_ctrl.sv
hw/rtl/gf2_bitmask_rank_unit.sv
hw/rtl/gbr_checker.sv
tb/sv/gf2_bitmask_rank_checker.sv
tb/sv/gf2_bitmask_rank_unit_tb.sv
